// File: rtl/core/assert_macros.svh
// Assertion macros used by the load-multiple sequencer RTL.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define LDM_ASSERT_NEVER(lbl, cond, msg) \
  `LDM_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/ldm_seq_pkg.sv
// Types and constants for the load-multiple address sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ldm_seq_pkg;

  localparam int unsigned LIST_W = 16;
  localparam int unsigned ADDR_W = 32;

  // Instruction word fields
  localparam int unsigned P_BIT  = 24;
  localparam int unsigned U_BIT  = 23;
  localparam int unsigned W_BIT  = 21;
  localparam int unsigned RN_LSB = 16;

  localparam logic [3:0]        RN_PC           = 4'hF;
  localparam logic [ADDR_W-1:0] ADDR_ALIGN_MASK = 32'hFFFF_FFFC;
  localparam logic [ADDR_W-1:0] WORD_STEP       = 32'd4;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_WB     = 2'd1,
    KIND_UNPRED = 2'd2
  } ldm_kind_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] base_value;
  } ldm_in_t;

  typedef struct packed {
    ldm_kind_e   kind;
    logic [3:0]  reg_index;
    logic [31:0] address;
    logic        last;
  } ldm_out_t;

  // Decoded command passed from front to back through the queue
  typedef struct packed {
    logic              unpred;
    logic              wback;
    logic [3:0]        rn;
    logic [LIST_W-1:0] reg_list;
    logic [ADDR_W-1:0] first_addr;
    logic [ADDR_W-1:0] wb_addr;
  } ldm_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ldm_q_stat_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } ldm_bk_state_e;

endpackage

// File: rtl/core/ldm_seq_front.sv
// Front end: decodes an LDM word and base into a queue command.
// Depends on ldm_seq_pkg.
`timescale 1ns / 1ps

module ldm_seq_front (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ldm_seq_pkg::ldm_in_t    in_data_i,
  input  ldm_seq_pkg::ldm_q_stat_t q_stat_i,
  output logic                    push_o,
  output ldm_seq_pkg::ldm_cmd_t   cmd_o
);
  import ldm_seq_pkg::*;

  logic [LIST_W-1:0] list;
  logic [ADDR_W-1:0] base;
  logic              p_bit, u_bit;
  logic [2:0]        nib_cnt [4];
  logic [4:0]        n_regs;
  logic [ADDR_W-1:0] span;
  logic [ADDR_W-1:0] first_off;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  assign list  = in_data_i.instruction[LIST_W-1:0];
  assign base  = in_data_i.base_value & ADDR_ALIGN_MASK;
  assign p_bit = in_data_i.instruction[P_BIT];
  assign u_bit = in_data_i.instruction[U_BIT];

  // Two-level population count: per nibble, then sum of nibbles
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nib_cnt[i] = {2'b00, list[4*i]}   + {2'b00, list[4*i+1]}
                 + {2'b00, list[4*i+2]} + {2'b00, list[4*i+3]};
    end
  end

  assign n_regs = ({2'b00, nib_cnt[0]} + {2'b00, nib_cnt[1]})
                + ({2'b00, nib_cnt[2]} + {2'b00, nib_cnt[3]});
  assign span   = {25'd0, n_regs, 2'b00};

  always_comb begin
    case ({p_bit, u_bit})
      2'b01:   first_off = '0;                 // increment after
      2'b11:   first_off = WORD_STEP;          // increment before
      2'b00:   first_off = WORD_STEP - span;   // decrement after
      default: first_off = '0 - span;          // decrement before
    endcase
  end

  always_comb begin
    cmd_o.unpred     = (in_data_i.instruction[RN_LSB+3:RN_LSB] == RN_PC);
    cmd_o.wback      = in_data_i.instruction[W_BIT];
    cmd_o.rn         = in_data_i.instruction[RN_LSB+3:RN_LSB];
    cmd_o.reg_list   = list;
    cmd_o.first_addr = base + first_off;
    cmd_o.wb_addr    = u_bit ? (base + span) : (base - span);
  end

endmodule

// File: rtl/core/ldm_seq_fifo.sv
// Small command queue between the front and back of the sequencer.
// Depends on ldm_seq_pkg.
`timescale 1ns / 1ps

module ldm_seq_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  ldm_seq_pkg::ldm_cmd_t    push_data_i,
  input  logic                     pop_i,
  output ldm_seq_pkg::ldm_cmd_t    pop_data_o,
  output ldm_seq_pkg::ldm_q_stat_t stat_o
);
  import ldm_seq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ldm_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/ldm_seq_back.sv
// Back end: walks one command's list, one beat per cycle unless the output stalls.
// Depends on ldm_seq_pkg.
`timescale 1ns / 1ps

module ldm_seq_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ldm_seq_pkg::ldm_q_stat_t q_stat_i,
  input  ldm_seq_pkg::ldm_cmd_t    cmd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ldm_seq_pkg::ldm_out_t    out_data_o
);
  import ldm_seq_pkg::*;

  ldm_bk_state_e     state_q, state_d;
  logic              unpred_q, unpred_d;
  logic              wback_q, wback_d;
  logic [3:0]        rn_q, rn_d;
  logic [LIST_W-1:0] list_q, list_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] wb_q, wb_d;
  logic              out_valid_q, out_valid_d;
  ldm_out_t          out_q, out_d;

  logic              out_load;
  logic              has_list, single, emit, done_now;
  logic [LIST_W-1:0] list_rest;
  logic [3:0]        low_idx;

  function automatic logic [3:0] lowest_set(input logic [LIST_W-1:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = LIST_W - 1; i >= 0; i--) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  assign out_load  = !out_valid_q || out_ready_i;
  assign has_list  = (list_q != '0);
  assign list_rest = list_q & (list_q - 1'b1);
  assign single    = (list_rest == '0);
  assign low_idx   = lowest_set(list_q);
  assign emit      = unpred_q || has_list || wback_q;
  // Empty list without writeback finishes with no beat
  assign done_now  = unpred_q || !has_list || (single && !wback_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_stat_i.empty) state_d = BK_RUN;
      BK_RUN:  if (out_load && done_now) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    pop_o       = 1'b0;
    unpred_d    = unpred_q;
    wback_d     = wback_q;
    rn_d        = rn_q;
    list_d      = list_q;
    addr_d      = addr_q;
    wb_d        = wb_q;
    out_valid_d = out_load ? 1'b0 : out_valid_q;
    out_d       = out_q;
    case (state_q)
      BK_IDLE: begin
        pop_o = !q_stat_i.empty;
        if (!q_stat_i.empty) begin
          unpred_d = cmd_i.unpred;
          wback_d  = cmd_i.wback;
          rn_d     = cmd_i.rn;
          list_d   = cmd_i.reg_list;
          addr_d   = cmd_i.first_addr;
          wb_d     = cmd_i.wb_addr;
        end
      end
      BK_RUN: begin
        if (out_load) begin
          out_valid_d = emit;
          if (unpred_q) begin
            out_d.kind      = KIND_UNPRED;
            out_d.reg_index = RN_PC;
            out_d.address   = '0;
            out_d.last      = 1'b1;
          end else if (has_list) begin
            out_d.kind      = KIND_LOAD;
            out_d.reg_index = low_idx;
            out_d.address   = addr_q;
            out_d.last      = single && !wback_q;
            list_d          = list_rest;
            addr_d          = addr_q + WORD_STEP;
          end else begin
            out_d.kind      = KIND_WB;
            out_d.reg_index = rn_q;
            out_d.address   = wb_q;
            out_d.last      = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unpred_q <= unpred_d;
    wback_q  <= wback_d;
    rn_q     <= rn_d;
    list_q   <= list_d;
    addr_q   <= addr_d;
    wb_q     <= wb_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/arm_ldm_address_sequencer_core.sv
// LDM address sequencer, top level: front decode, command queue, back sequencer.
// Path: an accepted instruction goes into the command queue, then into the back-end
// command registers, then its first beat into the output register (idle back end).
// Throughput: one beat per cycle within an instruction while the output is not stalled;
// the back end loads each command in its idle state before it walks the list.
// Reset: rst_ni asynchronous, active low; clears the queue and output valid.
`timescale 1ns / 1ps

module arm_ldm_address_sequencer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ldm_seq_pkg::ldm_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ldm_seq_pkg::ldm_out_t out_data_o
);
  import ldm_seq_pkg::*;

  // Front -> queue: one decoded command per accepted instruction beat.
  // The front works out the register count, the first load address and
  // the writeback base in the same cycle the beat is accepted.
  logic        q_push;
  ldm_cmd_t    q_in_cmd;
  ldm_cmd_t    q_head_cmd;
  logic        q_pop;
  ldm_q_stat_t q_stat;

  ldm_seq_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .cmd_o      (q_in_cmd)
  );

  // Command queue decouples the front from the back: the front keeps
  // taking instructions while the back is still walking a long list, until it is full.
  ldm_seq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in_cmd),
    .pop_i       (q_pop),
    .pop_data_o  (q_head_cmd),
    .stat_o      (q_stat)
  );

  // Back end: loads the head command, then one beat per cycle into the output register
  // while the output is not stalled. Loads go out lowest register first; the
  // writeback (if any) comes after them; a PC base gives a single beat.
  ldm_seq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (q_head_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Beat classification for the checks below
  logic unpred_beat;
  logic unpred_ok;
  logic wb_beat;

  assign unpred_beat = out_valid_o && (out_data_o.kind == KIND_UNPRED);
  assign unpred_ok   = out_data_o.last && (out_data_o.reg_index == RN_PC);
  assign wb_beat     = out_valid_o && (out_data_o.kind == KIND_WB);

  `include "assert_macros.svh"

  `LDM_ASSERT(a_unpred_single, unpred_beat |-> unpred_ok, "r15 flag must be a lone last beat")
  `LDM_ASSERT(a_wb_last, wb_beat |-> out_data_o.last, "writeback beat must close the instruction")
  `LDM_ASSERT_NEVER(a_q_overflow, q_push && q_stat.full, "push into a full command queue")

endmodule

// File: tb/tb.sv
// Self-checking bench for arm_ldm_address_sequencer_core: LDM words in, load/writeback beats out.
// Depends on ldm_seq_pkg for the port structs, kind codes and instruction field positions.
`timescale 1ns / 1ps

module tb;
  import ldm_seq_pkg::*;

  // Addressing mode as the {P, U} pair of the instruction word
  typedef enum logic [1:0] {
    MODE_DA = 2'b00,
    MODE_IA = 2'b01,
    MODE_DB = 2'b10,
    MODE_IB = 2'b11
  } ldm_mode_e;

  // Receiver behavior, reselected at random when its hold counter runs out
  typedef enum logic [1:0] {
    RX_STREAM   = 2'd0,
    RX_MOSTLY   = 2'd1,
    RX_SPARSE   = 2'd2,
    RX_PERIODIC = 2'd3
  } rx_mode_e;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 230;
  // Bits of the word that the sequencer ignores: 31..25, 22 and 20
  localparam logic [31:0] IGNORED_BITS = 32'hFE50_0000;

  // Expected-beat store plus the address predictor that fills it.
  class ldm_scoreboard;
    ldm_out_t expected_beats[$];
    int       mismatches;
    int       instructions;
    int       load_beats;
    int       wb_beats;
    int       unpred_beats;

    function new();
      mismatches   = 0;
      instructions = 0;
      load_beats   = 0;
      wb_beats     = 0;
      unpred_beats = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Expand one accepted LDM word into the beats it must produce.
    function void note_instruction(input ldm_in_t item);
      logic        pre;
      logic        up;
      logic        wback;
      logic [3:0]  rn;
      logic [15:0] reg_list;
      logic [31:0] base;
      logic [31:0] span;
      logic [31:0] addr;
      logic [31:0] new_base;
      int          count;
      int          total;
      int          k;
      int          r;
      ldm_out_t    beat;
      pre      = item.instruction[P_BIT];
      up       = item.instruction[U_BIT];
      wback    = item.instruction[W_BIT];
      rn       = item.instruction[RN_LSB +: 4];
      reg_list = item.instruction[LIST_W-1:0];
      base     = item.base_value & ADDR_ALIGN_MASK;
      instructions++;
      if (rn == RN_PC) begin
        beat.kind      = KIND_UNPRED;
        beat.reg_index = RN_PC;
        beat.address   = '0;
        beat.last      = 1'b1;
        expected_beats.push_back(beat);
        return;
      end
      count = $countones(reg_list);
      span  = WORD_STEP * 32'(count);
      if (up) begin
        addr     = pre ? base + WORD_STEP : base;
        new_base = base + span;
      end else begin
        addr     = pre ? base - span : base - span + WORD_STEP;
        new_base = base - span;
      end
      total = count + (wback ? 1 : 0);
      k     = 0;
      for (r = 0; r < LIST_W; r++) begin
        if (reg_list[r]) begin
          beat.kind      = KIND_LOAD;
          beat.reg_index = 4'(r);
          beat.address   = addr;
          beat.last      = (k + 1 == total);
          expected_beats.push_back(beat);
          addr += WORD_STEP;
          k++;
        end
      end
      if (wback) begin
        beat.kind      = KIND_WB;
        beat.reg_index = rn;
        beat.address   = new_base;
        beat.last      = 1'b1;
        expected_beats.push_back(beat);
      end
    endfunction

    task check_beat(input ldm_out_t got);
      ldm_out_t exp_beat;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d reg=%0d addr=%h last=%0b",
                                  got.kind, got.reg_index, got.address, got.last));
        return;
      end
      exp_beat = expected_beats.pop_front();
      case (exp_beat.kind)
        KIND_LOAD:   load_beats++;
        KIND_WB:     wb_beats++;
        default:     unpred_beats++;
      endcase
      if (got.kind !== exp_beat.kind)
        report_mismatch($sformatf("kind got %0d want %0d", got.kind, exp_beat.kind));
      if (got.reg_index !== exp_beat.reg_index)
        report_mismatch($sformatf("reg_index got %0d want %0d",
                                  got.reg_index, exp_beat.reg_index));
      if (got.address !== exp_beat.address)
        report_mismatch($sformatf("address got %h want %h (reg %0d)",
                                  got.address, exp_beat.address, exp_beat.reg_index));
      if (got.last !== exp_beat.last)
        report_mismatch($sformatf("last got %0b want %0b (reg %0d)",
                                  got.last, exp_beat.last, exp_beat.reg_index));
    endtask
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ldm_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ldm_out_t out_data_o;

  int unsigned   cycle_count = 0;
  ldm_scoreboard sb;
  ldm_in_t       stim_q[$];

  arm_ldm_address_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost beat ends up here.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d beats still expected", cycle_count, sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  // Monitors. Everything here runs in the active region of the clock edge, so it
  // sees the pre-edge values of both the bench's NBA-driven inputs and the DUT's
  // registered outputs: a handshake counts exactly when the DUT latched it.
  // Input is noted before the output check; as a word passes the queue and the back end
  // before its first beat, the expectation is always queued before that beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_instruction(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_data_o);
    end
  end

  // Receiver backpressure: a mode redrawn when its hold counter runs out, covering full-rate
  // stretches, light and heavy random stalls, and a fixed 4-of-5 pattern.
  rx_mode_e    rx_mode = RX_STREAM;
  int unsigned rx_hold = 0;

  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_hold = $urandom_range(16, 96);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_STREAM: begin
        out_ready_i <= 1'b1;
      end
      RX_MOSTLY: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      RX_SPARSE: begin
        out_ready_i <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready_i <= ((cycle_count % 5) != 0);
      end
    endcase
  end

  // Build one LDM word from its fields; optionally set all the don't-care bits.
  function automatic ldm_in_t make_ldm(input ldm_mode_e mode, input logic wback,
                                       input logic [3:0] rn, input logic [15:0] reg_list,
                                       input logic [31:0] base, input logic junk);
    ldm_in_t item;
    item.instruction                  = junk ? IGNORED_BITS : '0;
    item.instruction[P_BIT]           = mode[1];
    item.instruction[U_BIT]           = mode[0];
    item.instruction[W_BIT]           = wback;
    item.instruction[RN_LSB +: 4]     = rn;
    item.instruction[LIST_W-1:0]      = reg_list;
    item.base_value                   = base;
    return item;
  endfunction

  // Random LDM word: every field random, with the list density and the base
  // skewed so that empty lists, single registers, full lists and address wrap
  // at both ends of the space all show up regularly.
  function automatic ldm_in_t random_ldm();
    ldm_in_t     item;
    logic [15:0] reg_list;
    int unsigned pick;
    item.instruction = $urandom();
    item.base_value  = $urandom();
    pick = $urandom_range(0, 9);
    case (pick)
      0:       reg_list = '0;
      1:       reg_list = 16'h0001 << $urandom_range(0, 15);
      2:       reg_list = 16'($urandom()) | 16'($urandom());
      3:       reg_list = 16'($urandom()) & 16'($urandom()) & 16'($urandom());
      4:       reg_list = 16'hFFFF;
      default: reg_list = 16'($urandom());
    endcase
    item.instruction[LIST_W-1:0] = reg_list;
    pick = $urandom_range(0, 7);
    if (pick == 0) item.base_value = 32'hFFFF_FFC0 | 32'($urandom_range(0, 63));
    else if (pick == 1) item.base_value = 32'($urandom_range(0, 63));
    return item;
  endfunction

  // Sender: bursts of 1..12 back-to-back words; valid drops for an idle gap before
  // a burst unless no gap is drawn. Valid stays up across a burst; only the payload moves on.
  task automatic drive_stream();
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    while (stim_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b1;
      in_data_i  <= stim_q.pop_front();
      do @(posedge clk_i); while (!in_ready_o);
      burst_left--;
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : main
    sb = new();

    // Directed words: each mode with a full list, wrap at both ends of the
    // address space, unaligned bases, single-register lists, empty lists with
    // and without writeback, base r15 (with and without list/W), base in its
    // own list, the all-ones and all-zeros word, and every ignored bit set.
    stim_q.push_back(make_ldm(MODE_IA, 1'b1, 4'd0,  16'hFFFF, 32'h0000_1000, 1'b0));
    stim_q.push_back(make_ldm(MODE_IB, 1'b1, 4'd1,  16'hFFFF, 32'hFFFF_FFFF, 1'b0));
    stim_q.push_back(make_ldm(MODE_DA, 1'b1, 4'd2,  16'hFFFF, 32'h0000_0000, 1'b0));
    stim_q.push_back(make_ldm(MODE_DB, 1'b1, 4'd3,  16'hFFFF, 32'h0000_0003, 1'b0));
    stim_q.push_back(make_ldm(MODE_IA, 1'b0, 4'd4,  16'h0001, 32'hFFFF_FFFC, 1'b0));
    stim_q.push_back(make_ldm(MODE_DB, 1'b1, 4'd14, 16'h8000, 32'h0000_0000, 1'b0));
    stim_q.push_back(make_ldm(MODE_IB, 1'b0, 4'd5,  16'h0000, 32'h0000_0040, 1'b0));
    stim_q.push_back(make_ldm(MODE_DA, 1'b1, 4'd6,  16'h0000, 32'h1234_5677, 1'b0));
    stim_q.push_back(make_ldm(MODE_DB, 1'b0, 4'd7,  16'h0000, 32'h0000_0010, 1'b0));
    stim_q.push_back(make_ldm(MODE_IA, 1'b1, RN_PC, 16'hFFFF, 32'h0000_0100, 1'b0));
    stim_q.push_back(make_ldm(MODE_DB, 1'b0, RN_PC, 16'h0000, 32'h0000_0100, 1'b0));
    stim_q.push_back('{instruction: 32'hFFFF_FFFF, base_value: 32'hFFFF_FFFF});
    stim_q.push_back('{instruction: 32'h0000_0000, base_value: 32'h0000_0000});
    stim_q.push_back(make_ldm(MODE_IA, 1'b1, 4'd8,  16'h0F00, 32'h0000_2000, 1'b0));
    stim_q.push_back(make_ldm(MODE_DA, 1'b0, 4'd9,  16'h8001, 32'h0000_0004, 1'b0));
    stim_q.push_back(make_ldm(MODE_IB, 1'b1, 4'd10, 16'hAAAA, 32'h7FFF_FFFC, 1'b0));
    stim_q.push_back(make_ldm(MODE_DB, 1'b1, 4'd11, 16'h5555, 32'h8000_0000, 1'b0));
    stim_q.push_back(make_ldm(MODE_IA, 1'b0, 4'd12, 16'h00F0, 32'hFFFF_FFFE, 1'b1));
    stim_q.push_back(make_ldm(MODE_DA, 1'b1, 4'd13, 16'h2000, 32'h0000_0001, 1'b1));
    for (int i = 0; i < RANDOM_ITEMS; i++) stim_q.push_back(random_ldm());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_stream();

    // Drain: every expected beat back, then a quiet window in which a stray
    // extra beat would still be caught by the monitor.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d LDM words: %0d load beats, %0d writebacks, %0d r15-base flags",
             sb.instructions, sb.load_beats, sb.wb_beats, sb.unpred_beats);
    $display("All four addressing modes under bursty input and mixed output stalls; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ldm_seq_pkg.sv
rtl/core/ldm_seq_front.sv
rtl/core/ldm_seq_fifo.sv
rtl/core/ldm_seq_back.sv
rtl/core/arm_ldm_address_sequencer_core.sv
tb/tb.sv
